// ----- rtl/skin_tone_pixel_mask_defines.svh -----
// ----------------------------------------------------------------------------
// Skin tone pixel mask assertion macros
// Concurrent assertion shorthands for the skin tone pixel mask. They expand
// to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SKIN_TONE_PIXEL_MASK_DEFINES_SVH
`define SKIN_TONE_PIXEL_MASK_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define STPM_ASSERT_IMPLY(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STPM_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STPM_ASSERT_IMPLY(label, ck, rstn, ante, cons, msg)
`define STPM_ASSERT_NEXT(label, ck, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/stpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Skin tone pixel mask package
// Register indexes, reset values and fixed-point coefficients.
// ----------------------------------------------------------------------------
package stpm_pkg;

    localparam int CHAN_W   = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_REJECT_LOW  = 3'd0,
        CFG_HUE_REJECT_HIGH = 3'd1,
        CFG_CR_MIN          = 3'd2,
        CFG_CR_MAX          = 3'd3,
        CFG_CB_MIN          = 3'd4,
        CFG_CB_MAX          = 3'd5
    } cfg_index_t;

    localparam logic [CHAN_W-1:0] HUE_REJECT_LOW_RST  = 8'd19;
    localparam logic [CHAN_W-1:0] HUE_REJECT_HIGH_RST = 8'd240;
    localparam logic [CHAN_W-1:0] CR_MIN_RST          = 8'd125;
    localparam logic [CHAN_W-1:0] CR_MAX_RST          = 8'd160;
    localparam logic [CHAN_W-1:0] CB_MIN_RST          = 8'd102;
    localparam logic [CHAN_W-1:0] CB_MAX_RST          = 8'd128;

    // Hue gain numerator: 180 * 4096 / 6.
    localparam int HUE_GAIN_NUM = 122880;
    localparam int GAIN_W       = 17;
    localparam int HUE_FULL     = 180;

    // BT.601 luma and chroma weights in Q14.
    localparam logic [21:0] Y_COEF_R  = 22'd4899;
    localparam logic [21:0] Y_COEF_G  = 22'd9617;
    localparam logic [21:0] Y_COEF_B  = 22'd1868;
    localparam logic [21:0] Y_ROUND   = 22'd8192;
    localparam logic signed [23:0] CR_COEF    = 24'sd11682;
    localparam logic signed [23:0] CB_COEF    = 24'sd9241;
    localparam logic signed [23:0] CHROMA_OFS = 24'sd2105344;

    // Blue against green bounds in Q10.
    localparam logic signed [19:0] BG_SLOPE_A = 20'sd856;
    localparam logic signed [19:0] BG_SLOPE_B = 20'sd799;
    localparam logic signed [19:0] BG_SLOPE_C = 20'sd809;
    localparam logic signed [19:0] BG_OFS_A_UP = 20'sd45056;
    localparam logic signed [19:0] BG_OFS_A_LO = 20'sd14336;
    localparam logic signed [19:0] BG_OFS_B_UP = 20'sd43008;
    localparam logic signed [19:0] BG_OFS_C_LO = 20'sd68608;

endpackage

// ----- rtl/skin_tone_pixel_mask.sv -----
// ----------------------------------------------------------------------------
// Skin tone pixel mask
// Five-stage pipeline that passes skin colored pixels and blanks the rest.
// ----------------------------------------------------------------------------
// One BGR pixel enters per clock while s_axis_tready is high and leaves in
// order, as the same pixel when it passes the hue, Cr/Cb and blue-to-green
// tests, or as black otherwise; tuser carries the skin flag. Each of the five
// register stages holds its own valid bit and takes a new item whenever it is
// empty or its successor moves, so a stalled output only stops the stages
// behind it and bubbles close up. The depth is set by the hue path: gain
// lookup, one signed multiply, then rounding and wrap. Write the window
// registers only while no item is in flight.
`include "skin_tone_pixel_mask_defines.svh"

module skin_tone_pixel_mask
    import stpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,  // blue, green, red
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,  // out_blue, out_green, out_red
    output logic                 m_axis_tuser,  // is_skin
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAN_W-1:0]    cfg_data
);

    // Configuration registers
    logic [CHAN_W-1:0] hue_low_reg, hue_high_reg;
    logic [CHAN_W-1:0] cr_min_reg, cr_max_reg, cb_min_reg, cb_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg  <= HUE_REJECT_LOW_RST;
            hue_high_reg <= HUE_REJECT_HIGH_RST;
            cr_min_reg   <= CR_MIN_RST;
            cr_max_reg   <= CR_MAX_RST;
            cb_min_reg   <= CB_MIN_RST;
            cb_max_reg   <= CB_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HUE_REJECT_LOW:  hue_low_reg  <= cfg_data;
                CFG_HUE_REJECT_HIGH: hue_high_reg <= cfg_data;
                CFG_CR_MIN:          cr_min_reg   <= cfg_data;
                CFG_CR_MAX:          cr_max_reg   <= cfg_data;
                CFG_CB_MIN:          cb_min_reg   <= cfg_data;
                CFG_CB_MAX:          cb_max_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Hue gain table, round(122880 / d); a grey pixel gets zero gain.
    logic [GAIN_W-1:0] gain_tab [256];

    assign gain_tab[0] = '0;
    for (genvar gi = 1; gi < 256; gi++)
    begin : g_gain
        localparam int Div  = gi;
        localparam int Gain = (HUE_GAIN_NUM + Div / 2) / Div;
        assign gain_tab[gi] = GAIN_W'(Gain);
    end

    // Stage handshake
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

    assign s5_rdy = !s5_vld_reg || m_axis_tready;
    assign s4_rdy = !s4_vld_reg || s5_rdy;
    assign s3_rdy = !s3_vld_reg || s4_rdy;
    assign s2_rdy = !s2_vld_reg || s3_rdy;
    assign s1_rdy = !s1_vld_reg || s2_rdy;
    assign s_axis_tready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy) s1_vld_reg <= s_axis_tvalid;
            if (s2_rdy) s2_vld_reg <= s1_vld_reg;
            if (s3_rdy) s3_vld_reg <= s2_vld_reg;
            if (s4_rdy) s4_vld_reg <= s3_vld_reg;
            if (s5_rdy) s5_vld_reg <= s4_vld_reg;
        end
    end

    // Stage 1: max/min, raw hue, luma, blue-to-green bounds
    logic [CHAN_W-1:0] in_b, in_g, in_r, mx, mn, d_next;
    logic signed [11:0] bs, gs, rs, ds, h_next;
    logic [21:0] ysum;
    logic [CHAN_W-1:0] y_next;
    logic signed [19:0] bg_lhs, g20, bg_up_a, bg_lo_a, bg_up_b, bg_lo_c;
    logic bg_ok_next;

    assign in_b = s_axis_tdata[7:0];
    assign in_g = s_axis_tdata[15:8];
    assign in_r = s_axis_tdata[23:16];

    always_comb
    begin
        mx = in_r;
        if (in_g > mx) mx = in_g;
        if (in_b > mx) mx = in_b;
        mn = in_r;
        if (in_g < mn) mn = in_g;
        if (in_b < mn) mn = in_b;
        d_next = mx - mn;
        bs = signed'({4'd0, in_b});
        gs = signed'({4'd0, in_g});
        rs = signed'({4'd0, in_r});
        ds = signed'({4'd0, d_next});
        if (mx == in_r)
            h_next = gs - bs;
        else if (mx == in_g)
            h_next = bs - rs + (ds <<< 1);
        else
            h_next = rs - gs + (ds <<< 2);

        ysum = Y_COEF_R * 22'(in_r) + Y_COEF_G * 22'(in_g)
             + Y_COEF_B * 22'(in_b) + Y_ROUND;
        y_next = ysum[21:14];

        bg_lhs  = signed'({2'b00, in_b, 10'd0});
        g20     = signed'({12'd0, in_g});
        bg_up_a = BG_SLOPE_A * g20 + BG_OFS_A_UP;
        bg_lo_a = BG_SLOPE_A * g20 - BG_OFS_A_LO;
        bg_up_b = BG_SLOPE_B * g20 + BG_OFS_B_UP;
        bg_lo_c = BG_SLOPE_C * g20 - BG_OFS_C_LO;
        bg_ok_next = !(bg_lhs > bg_up_a || bg_lhs < bg_lo_a ||
                       bg_lhs > bg_up_b || bg_lhs < bg_lo_c);
    end

    logic [CHAN_W-1:0] s1_b_reg, s1_g_reg, s1_r_reg, s1_d_reg, s1_y_reg;
    logic signed [11:0] s1_h_reg;
    logic s1_bg_ok_reg;

    // Stage 2: gain lookup, chroma differences
    logic signed [8:0] cr_diff_next, cb_diff_next;

    assign cr_diff_next = signed'({1'b0, s1_r_reg}) - signed'({1'b0, s1_y_reg});
    assign cb_diff_next = signed'({1'b0, s1_b_reg}) - signed'({1'b0, s1_y_reg});

    logic [CHAN_W-1:0] s2_b_reg, s2_g_reg, s2_r_reg;
    logic signed [11:0] s2_h_reg;
    logic [GAIN_W-1:0] s2_k_reg;
    logic signed [8:0] s2_cr_diff_reg, s2_cb_diff_reg;
    logic s2_bg_ok_reg;

    // Stage 3: hue product, chroma products
    logic signed [29:0] hk_next;
    logic signed [23:0] cr_v_next, cb_v_next;

    assign hk_next   = 30'(s2_h_reg) * signed'({13'd0, s2_k_reg});
    assign cr_v_next = CR_COEF * 24'(s2_cr_diff_reg) + CHROMA_OFS;
    assign cb_v_next = CB_COEF * 24'(s2_cb_diff_reg) + CHROMA_OFS;

    logic [CHAN_W-1:0] s3_b_reg, s3_g_reg, s3_r_reg;
    logic signed [29:0] s3_hk_reg;
    logic signed [23:0] s3_cr_v_reg, s3_cb_v_reg;
    logic s3_bg_ok_reg;

    // Stage 4: hue rounding and wrap, chroma saturation
    logic signed [29:0] hue_sum, hue_shr;
    logic signed [9:0] hue_w, hue_fix;
    logic [CHAN_W-1:0] hue_next, cr_next, cb_next;

    always_comb
    begin
        hue_sum = s3_hk_reg + 30'sd2048;
        hue_shr = hue_sum >>> 12;
        hue_w   = hue_shr[9:0];
        hue_fix = (hue_w < 10'sd0) ? hue_w + 10'(HUE_FULL) : hue_w;
        hue_next = hue_fix[7:0];

        if (s3_cr_v_reg[23])
            cr_next = '0;
        else if (s3_cr_v_reg[22])
            cr_next = '1;
        else
            cr_next = s3_cr_v_reg[21:14];

        if (s3_cb_v_reg[23])
            cb_next = '0;
        else if (s3_cb_v_reg[22])
            cb_next = '1;
        else
            cb_next = s3_cb_v_reg[21:14];
    end

    logic [CHAN_W-1:0] s4_b_reg, s4_g_reg, s4_r_reg, s4_hue_reg, s4_cr_reg, s4_cb_reg;
    logic s4_bg_ok_reg;

    // Stage 5: window compares and output register
    logic hue_ok, chroma_ok, skin_next;
    logic [23:0] pix_next;

    always_comb
    begin
        hue_ok    = !((hue_low_reg < s4_hue_reg) && (s4_hue_reg < hue_high_reg));
        chroma_ok = (s4_cr_reg >= cr_min_reg) && (s4_cr_reg <= cr_max_reg) &&
                    (s4_cb_reg >= cb_min_reg) && (s4_cb_reg <= cb_max_reg);
        skin_next = hue_ok && chroma_ok && s4_bg_ok_reg;
        pix_next  = skin_next ? {s4_r_reg, s4_g_reg, s4_b_reg} : '0;
    end

    logic [23:0] s5_pix_reg;
    logic s5_skin_reg;

    // Payload registers load whenever their stage may advance.
    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            s1_b_reg     <= in_b;
            s1_g_reg     <= in_g;
            s1_r_reg     <= in_r;
            s1_d_reg     <= d_next;
            s1_h_reg     <= h_next;
            s1_y_reg     <= y_next;
            s1_bg_ok_reg <= bg_ok_next;
        end
        if (s2_rdy)
        begin
            s2_b_reg       <= s1_b_reg;
            s2_g_reg       <= s1_g_reg;
            s2_r_reg       <= s1_r_reg;
            s2_h_reg       <= s1_h_reg;
            s2_k_reg       <= gain_tab[s1_d_reg];
            s2_cr_diff_reg <= cr_diff_next;
            s2_cb_diff_reg <= cb_diff_next;
            s2_bg_ok_reg   <= s1_bg_ok_reg;
        end
        if (s3_rdy)
        begin
            s3_b_reg     <= s2_b_reg;
            s3_g_reg     <= s2_g_reg;
            s3_r_reg     <= s2_r_reg;
            s3_hk_reg    <= hk_next;
            s3_cr_v_reg  <= cr_v_next;
            s3_cb_v_reg  <= cb_v_next;
            s3_bg_ok_reg <= s2_bg_ok_reg;
        end
        if (s4_rdy)
        begin
            s4_b_reg     <= s3_b_reg;
            s4_g_reg     <= s3_g_reg;
            s4_r_reg     <= s3_r_reg;
            s4_hue_reg   <= hue_next;
            s4_cr_reg    <= cr_next;
            s4_cb_reg    <= cb_next;
            s4_bg_ok_reg <= s3_bg_ok_reg;
        end
        if (s5_rdy)
        begin
            s5_pix_reg  <= pix_next;
            s5_skin_reg <= skin_next;
        end
    end

    assign m_axis_tvalid = s5_vld_reg;
    assign m_axis_tdata  = s5_pix_reg;
    assign m_axis_tuser  = s5_skin_reg;

    `STPM_ASSERT_IMPLY(a_blank_when_not_skin, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 24'd0, "rejected pixel is not black")
    `STPM_ASSERT_IMPLY(a_ready_when_drained, clk, rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with an empty output stage")
    `STPM_ASSERT_NEXT(a_cr_min_write, clk, rst_n, cfg_valid && cfg_ready && cfg_index == CFG_CR_MIN, cr_min_reg == $past(cfg_data), "Cr lower bound write lost")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Skin tone pixel mask testbench
// Streams BGR pixels through the mask under several window settings, with
// random gaps on the input and random stalls on the output. Each accepted
// pixel is run through an integer model of the hue, chroma and blue-to-green
// tests, and every output item is compared field by field with the oldest
// expected pixel.
// ----------------------------------------------------------------------------
module testbench;
    import stpm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       skin;
    } masked_pixel_t;

    class skin_mask_scoreboard;
        logic [7:0]    window_reg [0:5];
        masked_pixel_t expected_pixels [$];
        int            mismatches;
        int            pixels_in;
        int            pixels_out;
        int            skin_hits;

        function new();
            window_reg[CFG_HUE_REJECT_LOW]  = 8'd19;
            window_reg[CFG_HUE_REJECT_HIGH] = 8'd240;
            window_reg[CFG_CR_MIN]          = 8'd125;
            window_reg[CFG_CR_MAX]          = 8'd160;
            window_reg[CFG_CB_MIN]          = 8'd102;
            window_reg[CFG_CB_MAX]          = 8'd128;
            mismatches = 0;
            pixels_in  = 0;
            pixels_out = 0;
            skin_hits  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            // Indexes past the last register are dropped by the block.
            if (idx <= CFG_CB_MAX)
                window_reg[idx] = val;
        endfunction

        // Hue in halved degrees, 0..179, rounded with a gain of 180*4096/(6d).
        function int hue_of(int b, int g, int r);
            int mx, mn, d, h, k, hv;
            mx = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            mn = r;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            if (mx == r)
                h = g - b;
            else if (mx == g)
                h = b - r + 2 * d;
            else
                h = r - g + 4 * d;
            k = (d > 0) ? (122880 + d / 2) / d : 0;
            hv = (h * k + 2048) >>> 12;
            if (hv < 0)
                hv += 180;
            return hv;
        endfunction

        function int chroma_of(int diff, int coef);
            int v;
            v = diff * coef + 128 * 16384 + 8192;
            if (v < 0)
                return 0;
            v = v >>> 14;
            return (v > 255) ? 255 : v;
        endfunction

        function void note_pixel(logic [7:0] b8, logic [7:0] g8, logic [7:0] r8);
            int b, g, r, hue, luma, cr, cb, scaled_b;
            bit hue_ok, chroma_ok, bg_ok;
            masked_pixel_t exp_px;
            b = b8;
            g = g8;
            r = r8;
            hue = hue_of(b, g, r);
            hue_ok = !((int'(window_reg[CFG_HUE_REJECT_LOW]) < hue) &&
                       (hue < int'(window_reg[CFG_HUE_REJECT_HIGH])));
            luma = (4899 * r + 9617 * g + 1868 * b + 8192) >>> 14;
            cr = chroma_of(r - luma, 11682);
            cb = chroma_of(b - luma, 9241);
            chroma_ok = cr >= window_reg[CFG_CR_MIN] && cr <= window_reg[CFG_CR_MAX] &&
                        cb >= window_reg[CFG_CB_MIN] && cb <= window_reg[CFG_CB_MAX];
            scaled_b = 1024 * b;
            bg_ok = !(scaled_b > 856 * g + 44 * 1024 ||
                      scaled_b < 856 * g - 14 * 1024 ||
                      scaled_b > 799 * g + 42 * 1024 ||
                      scaled_b < 809 * g - 67 * 1024);
            exp_px.skin  = hue_ok && chroma_ok && bg_ok;
            exp_px.blue  = exp_px.skin ? b8 : 8'd0;
            exp_px.green = exp_px.skin ? g8 : 8'd0;
            exp_px.red   = exp_px.skin ? r8 : 8'd0;
            expected_pixels.push_back(exp_px);
            pixels_in++;
        endfunction

        function void check_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_pixel(logic [23:0] data, logic skin);
            masked_pixel_t exp_px;
            pixels_out++;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected output item, expected none, actual data %h skin %0d",
                         $time, data, skin);
                mismatches++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            check_field("out_blue", exp_px.blue, data[7:0]);
            check_field("out_green", exp_px.green, data[15:8]);
            check_field("out_red", exp_px.red, data[23:16]);
            check_field("is_skin", exp_px.skin, skin);
            if (skin)
                skin_hits++;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata;  // blue, green, red
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;  // out_blue, out_green, out_red
    logic                 m_axis_tuser;  // is_skin
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CHAN_W-1:0]    cfg_data;

    skin_mask_scoreboard sb;
    bit                  no_idle;
    int                  cycle_count;
    int                  cfg_writes;
    int                  settings_used;

    skin_tone_pixel_mask i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output side: a random stall before each item, none while no_idle is set.
    initial
    begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tuser);
    end

    // Valid is left high after an item so that back-to-back items never
    // lower and raise it in the same step.
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, g, b};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_pixel(b, g, r);
    endtask

    // Stops the input stream and waits until every pixel has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic program_windows(input logic [7:0] hue_lo, input logic [7:0] hue_hi,
                                   input logic [7:0] cr_lo, input logic [7:0] cr_hi,
                                   input logic [7:0] cb_lo, input logic [7:0] cb_hi);
        wait_drained();
        write_window_reg(CFG_HUE_REJECT_LOW, hue_lo);
        write_window_reg(CFG_HUE_REJECT_HIGH, hue_hi);
        write_window_reg(CFG_CR_MIN, cr_lo);
        write_window_reg(CFG_CR_MAX, cr_hi);
        write_window_reg(CFG_CB_MIN, cb_lo);
        write_window_reg(CFG_CB_MAX, cb_hi);
        // Writes to the spare indexes must leave every window alone.
        if ($urandom_range(0, 1))
            write_window_reg(CFG_IDX_SPARE_A, 8'($urandom));
        else
            write_window_reg(CFG_IDX_SPARE_B, 8'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Mostly skin-like pixels, with blue kept near 0.8 of green so that the
    // blue-to-green bounds pass often; the rest is uniform noise.
    task automatic send_random_pixels(input int count);
        int r, g, b;
        for (int n = 0; n < count; n++)
        begin
            if (n % 25 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 6)
            begin
                r = $urandom_range(96, 255);
                g = $urandom_range(r * 45 / 100, r * 90 / 100);
                b = g * 800 / 1024 + $urandom_range(0, 40) - 20;
                if (b < 0) b = 0;
                if (b > 255) b = 255;
            end
            else
            begin
                r = $urandom_range(0, 255);
                g = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            send_pixel(8'(b), 8'(g), 8'(r));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        logic [7:0] lo, hi;
        sb = new();
        no_idle       = 1'b0;
        cfg_writes    = 0;
        settings_used = 1;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_HUE_REJECT_LOW;
        cfg_data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels at the reset windows.
        send_pixel(8'd0, 8'd0, 8'd0);         // black, grey hue
        send_pixel(8'd255, 8'd255, 8'd255);   // white
        send_pixel(8'd128, 8'd128, 8'd128);   // mid grey
        send_pixel(8'd0, 8'd0, 8'd255);       // pure red, Cr saturates high
        send_pixel(8'd0, 8'd255, 8'd0);       // pure green, Cr below the window
        send_pixel(8'd255, 8'd0, 8'd0);       // pure blue, Cb at its top
        send_pixel(8'd0, 8'd255, 8'd255);     // yellow
        send_pixel(8'd255, 8'd255, 8'd0);     // cyan
        send_pixel(8'd255, 8'd0, 8'd255);     // magenta
        send_pixel(8'd120, 8'd150, 8'd200);   // typical skin tone
        send_pixel(8'd100, 8'd130, 8'd180);   // another skin tone
        send_pixel(8'd50, 8'd200, 8'd200);    // red and green tie for max
        send_pixel(8'd200, 8'd50, 8'd200);    // red and blue tie for max
        send_pixel(8'd100, 8'd50, 8'd200);    // red max, negative raw hue wraps
        send_pixel(8'd1, 8'd0, 8'd0);         // smallest nonzero spread
        send_pixel(8'd240, 8'd255, 8'd255);   // blue just inside the upper bound
        send_pixel(8'd241, 8'd255, 8'd255);   // blue just past the upper bound
        send_pixel(8'd69, 8'd100, 8'd130);    // blue just under the lower bound
        send_pixel(8'd44, 8'd0, 8'd60);       // green zero, blue past the upper offset
        send_pixel(8'd90, 8'd120, 8'd170);    // skin, hue below the reject window
        send_pixel(8'd254, 8'd1, 8'd127);     // blue near full scale, green near zero

        send_random_pixels(100);

        // Widest chroma windows, hue accepts only zero.
        program_windows(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd100, 8'd50, 8'd200);
        send_random_pixels(50);

        // Hue window empty, chroma windows open.
        program_windows(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255);
        send_random_pixels(40);

        // Inverted chroma windows never accept.
        program_windows(8'd19, 8'd240, 8'd200, 8'd100, 8'd130, 8'd90);
        send_random_pixels(30);

        // Hue window one step wide is still empty.
        program_windows(8'd20, 8'd21, 8'd110, 8'd170, 8'd90, 8'd140);
        send_random_pixels(40);

        for (int s = 0; s < 3; s++)
        begin
            lo = 8'($urandom_range(0, 60));
            hi = 8'($urandom_range(100, 255));
            program_windows(lo, hi, 8'($urandom_range(100, 140)),
                            8'($urandom_range(140, 255)),
                            8'($urandom_range(60, 110)), 8'($urandom_range(110, 180)));
            send_random_pixels(45);
            if (s == 1)
            begin
                // The sender holds off until the pipeline is empty.
                wait_drained();
                send_random_pixels(15);
            end
        end

        program_windows(HUE_REJECT_LOW_RST, HUE_REJECT_HIGH_RST, CR_MIN_RST,
                        CR_MAX_RST, CB_MIN_RST, CB_MAX_RST);
        send_random_pixels(60);

        wait_drained();
        $display("Checked %0d pixels (%0d skin) under %0d window settings,",
                 sb.pixels_out, sb.skin_hits, settings_used);
        $display("with %0d register writes and random gaps and stalls on both sides.",
                 cfg_writes);
        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d pixels missing", sb.mismatches,
                     sb.expected_pixels.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
